### hw/rtl/assert_macros.svh
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MEC_ASSERT(name, clk_s, rst_s, prop) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) prop) \
    else $error("assertion failed");
`define MEC_ASSERT_CLK(name, prop) `MEC_ASSERT(name, clk, rst, prop)
`else
`define MEC_ASSERT(name, clk_s, rst_s, prop)
`define MEC_ASSERT_CLK(name, prop)
`endif
`endif

### hw/rtl/mec_pkg.sv
package mec_pkg;

  // one input beat
  typedef struct packed {
    logic [11:0] column;
    logic [11:0] row;
  } in_t;

  // one result beat
  typedef struct packed {
    logic [20:0] iteration_count;
    logic        escaped;
    logic [51:0] escape_modulus_sq;
  } out_t;

  // point in the complex plane, signed fixed point
  typedef struct packed {
    logic signed [47:0] re;
    logic signed [47:0] im;
  } point_t;

  // register map
  typedef enum logic [1:0] {
    REG_ORIGIN_RE = 2'd0,
    REG_ORIGIN_IM = 2'd1,
    REG_STEP      = 2'd2,
    REG_LIMIT     = 2'd3
  } reg_idx_t;

  localparam logic signed [47:0] ORIGIN_RE_RST = 48'shE000_0000_0000;
  localparam logic signed [47:0] ORIGIN_IM_RST = 48'shF000_0000_0000;
  localparam logic [46:0]        STEP_RST      = 47'd17592186044;
  localparam logic [19:0]        LIMIT_RST     = 20'd256;

  localparam logic signed [47:0] Z_MAX   = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] Z_MIN   = 48'sh8000_0000_0000;
  localparam logic [60:0]        PCAP    = 61'h1000_0000_0000_0000;
  localparam logic [51:0]        MOD_MAX = 52'hF_FFFF_FFFF_FFFF;

  // clamp to the signed 48 bit range
  function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
    logic signed [47:0] r;
    if (v > 64'(Z_MAX)) r = Z_MAX;
    else if (v < 64'(Z_MIN)) r = Z_MIN;
    else r = v[47:0];
    return r;
  endfunction

endpackage

### hw/rtl/mandelbrot_escape_count.sv
// Escape-time counter for one sample point per beat. The front stage turns column and row
// into c, a two-entry queue decouples it from the iteration engine, and the engine runs
// z = z*z + c with three 48x24 multipliers, so each complex step runs through the low
// partials, high partials and update states. Phase one evaluates the bailout once per batch
// of BATCH steps; phase two replays at most BATCH single steps. The default limit is 256.
// The engine works on one item at a time while the next waits in the queue and a finished
// result waits in the output register.
module mandelbrot_escape_count #(
  parameter int BATCH      = 8,
  parameter int FRAC_BITS  = 44,
  parameter int INDEX_BITS = 12
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  mec_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output mec_pkg::out_t out_data,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [63:0]   pwdata,
  output logic [63:0]   prdata,
  output logic          pready
);

  logic signed [47:0] origin_re;
  logic signed [47:0] origin_im;
  logic [46:0]        step_size;
  logic [19:0]        iteration_limit;
  mec_pkg::reg_idx_t  reg_idx;
  logic               wr_en;

  logic               c_valid, c_ready;
  mec_pkg::point_t    c_data;
  logic               q_valid, q_ready;
  mec_pkg::point_t    q_data;

  // configuration registers
  assign pready  = 1'b1;
  assign reg_idx = mec_pkg::reg_idx_t'(paddr[4:3]);
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_re       <= mec_pkg::ORIGIN_RE_RST;
      origin_im       <= mec_pkg::ORIGIN_IM_RST;
      step_size       <= mec_pkg::STEP_RST;
      iteration_limit <= mec_pkg::LIMIT_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        mec_pkg::REG_ORIGIN_RE: origin_re       <= pwdata[47:0];
        mec_pkg::REG_ORIGIN_IM: origin_im       <= pwdata[47:0];
        mec_pkg::REG_STEP:      step_size       <= pwdata[46:0];
        mec_pkg::REG_LIMIT:     iteration_limit <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (reg_idx)
      mec_pkg::REG_ORIGIN_RE: prdata = 64'(origin_re);
      mec_pkg::REG_ORIGIN_IM: prdata = 64'(origin_im);
      mec_pkg::REG_STEP:      prdata = {17'd0, step_size};
      mec_pkg::REG_LIMIT:     prdata = {44'd0, iteration_limit};
      default:                prdata = '0;
    endcase
  end

  mec_front #(
    .INDEX_BITS(INDEX_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .origin_re (origin_re),
    .origin_im (origin_im),
    .step_size (step_size),
    .c_valid   (c_valid),
    .c_ready   (c_ready),
    .c_data    (c_data)
  );

  mec_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (c_valid),
    .wr_ready (c_ready),
    .wr_data  (c_data),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_data)
  );

  mec_back #(
    .BATCH     (BATCH),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .c_valid         (q_valid),
    .c_ready         (q_ready),
    .c_data          (q_data),
    .iteration_limit (iteration_limit),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data)
  );

endmodule

### hw/rtl/mec_front.sv
module mec_front #(
  parameter int INDEX_BITS = 12
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  mec_pkg::in_t       in_data,
  input  logic signed [47:0] origin_re,
  input  logic signed [47:0] origin_im,
  input  logic [46:0]        step_size,
  output logic               c_valid,
  input  logic               c_ready,
  output mec_pkg::point_t    c_data
);

  localparam logic [11:0] IDX_MASK = 12'((64'd1 << INDEX_BITS) - 64'd1);

  logic        s1_valid;
  logic [58:0] prod_re;
  logic [58:0] prod_im;

  // offset stage, holds index times step
  assign in_ready = !s1_valid || c_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      prod_re <= 59'(in_data.column & IDX_MASK) * 59'(step_size);
      prod_im <= 59'(in_data.row & IDX_MASK) * 59'(step_size);
    end
  end

  // add the corner and clamp
  assign c_valid   = s1_valid;
  assign c_data.re = mec_pkg::sat48(64'(origin_re) + $signed({5'd0, prod_re}));
  assign c_data.im = mec_pkg::sat48(64'(origin_im) + $signed({5'd0, prod_im}));

endmodule

### hw/rtl/mec_fifo.sv
`include "assert_macros.svh"

module mec_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  mec_pkg::point_t wr_data,
  output logic            rd_valid,
  input  logic            rd_ready,
  output mec_pkg::point_t rd_data
);

  localparam int DEPTH = 2;

  mec_pkg::point_t mem [DEPTH];
  logic [1:0]      count;
  logic            wr_ptr;
  logic            rd_ptr;
  logic            push;
  logic            pop;

  assign wr_ready = count != 2'(DEPTH);
  assign rd_valid = count != 2'd0;
  assign rd_data  = mem[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      if (push && !pop) count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_data;
  end

  `MEC_ASSERT_CLK(a_fifo_level, count <= 2'(DEPTH))
  `MEC_ASSERT_CLK(a_fifo_fill, (push && !pop) |=> count == $past(count) + 2'd1)

endmodule

### hw/rtl/mec_back.sv
`include "assert_macros.svh"

module mec_back #(
  parameter int BATCH     = 8,
  parameter int FRAC_BITS = 44
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            c_valid,
  output logic            c_ready,
  input  mec_pkg::point_t c_data,
  input  logic [19:0]     iteration_limit,
  output logic            out_valid,
  input  logic            out_ready,
  output mec_pkg::out_t   out_data
);

  localparam int          ITW  = $clog2(BATCH + 1);
  localparam logic [63:0] BAIL = 64'(20) << FRAC_BITS;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_MUL_LO = 5'b00010,
    S_MUL_HI = 5'b00100,
    S_EVAL   = 5'b01000,
    S_FIN    = 5'b10000
  } state_t;

  state_t             state;
  logic signed [47:0] cr, ci, zr, zi, sr, si;
  logic [ITW-1:0]     it_cnt;
  logic [20:0]        count;
  logic [20:0]        done;
  logic               phase2;
  logic               esc;
  logic [51:0]        esc_mod;
  logic [71:0]        pp_rr, pp_ii, pp_ri;
  logic [95:0]        full_rr, full_ii, full_ri;

  logic [47:0]        mr, mi;
  logic [60:0]        sq_rr, sq_ii, sq_ri;
  logic signed [63:0] ri_s, nr, ni;
  logic [61:0]        mod_full;
  logic [51:0]        modv;
  logic               over;
  logic [20:0]        done_step;

  // scale a full product and cap its magnitude
  function automatic logic [60:0] capq(input logic [95:0] p);
    logic [95:0] q;
    q = p >> FRAC_BITS;
    return (q > 96'(mec_pkg::PCAP)) ? mec_pkg::PCAP : q[60:0];
  endfunction

  // magnitudes of the current z
  assign mr = zr[47] ? 48'(-zr) : 48'(zr);
  assign mi = zi[47] ? 48'(-zi) : 48'(zi);

  // next z and squared modulus from the registered products
  always_comb begin
    sq_rr     = capq(full_rr);
    sq_ii     = capq(full_ii);
    sq_ri     = capq(full_ri);
    ri_s      = (zr[47] ^ zi[47]) ? -$signed({3'd0, sq_ri}) : $signed({3'd0, sq_ri});
    nr        = $signed({3'd0, sq_rr}) - $signed({3'd0, sq_ii}) + 64'(cr);
    ni        = (ri_s <<< 1) + 64'(ci);
    mod_full  = {1'b0, sq_rr} + {1'b0, sq_ii};
    modv      = (mod_full > 62'(mec_pkg::MOD_MAX)) ? mec_pkg::MOD_MAX : mod_full[51:0];
    over      = {12'd0, modv} > BAIL;
    done_step = done + 21'(BATCH);
  end

  assign c_ready = state == S_IDLE;

  // iteration sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_FIN) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (c_valid) begin
            cr      <= c_data.re;
            ci      <= c_data.im;
            zr      <= c_data.re;
            zi      <= c_data.im;
            sr      <= c_data.re;
            si      <= c_data.im;
            it_cnt  <= '0;
            count   <= '0;
            done    <= '0;
            phase2  <= 1'b0;
            esc     <= 1'b0;
            esc_mod <= '0;
            state   <= S_MUL_LO;
          end
        end
        S_MUL_LO: begin
          pp_rr <= 72'(mr) * 72'(mr[23:0]);
          pp_ii <= 72'(mi) * 72'(mi[23:0]);
          pp_ri <= 72'(mr) * 72'(mi[23:0]);
          state <= S_MUL_HI;
        end
        S_MUL_HI: begin
          full_rr <= 96'(pp_rr) + (96'(72'(mr) * 72'(mr[47:24])) << 24);
          full_ii <= 96'(pp_ii) + (96'(72'(mi) * 72'(mi[47:24])) << 24);
          full_ri <= 96'(pp_ri) + (96'(72'(mr) * 72'(mi[47:24])) << 24);
          state   <= S_EVAL;
        end
        S_EVAL: begin
          state <= S_MUL_LO;
          if (!phase2) begin
            if (it_cnt == ITW'(BATCH)) begin
              if (over) begin
                // batch escaped, replay it one step at a time
                phase2 <= 1'b1;
                zr     <= sr;
                zi     <= si;
                it_cnt <= '0;
              end else begin
                count <= count + 21'(BATCH);
                done  <= done_step;
                if (done_step >= {1'b0, iteration_limit}) begin
                  phase2 <= 1'b1;
                  zr     <= '0;
                  zi     <= '0;
                  it_cnt <= '0;
                end else begin
                  sr     <= zr;
                  si     <= zi;
                  zr     <= mec_pkg::sat48(nr);
                  zi     <= mec_pkg::sat48(ni);
                  it_cnt <= ITW'(1);
                end
              end
            end else begin
              zr     <= mec_pkg::sat48(nr);
              zi     <= mec_pkg::sat48(ni);
              it_cnt <= it_cnt + ITW'(1);
            end
          end else begin
            if (it_cnt != '0 && over) begin
              esc     <= 1'b1;
              esc_mod <= modv;
              state   <= S_FIN;
            end else begin
              if (it_cnt != '0) count <= count + 21'd1;
              if (it_cnt == ITW'(BATCH)) begin
                state <= S_FIN;
              end else begin
                zr     <= mec_pkg::sat48(nr);
                zi     <= mec_pkg::sat48(ni);
                it_cnt <= it_cnt + ITW'(1);
              end
            end
          end
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            out_data.iteration_count   <= count;
            out_data.escaped           <= esc;
            out_data.escape_modulus_sq <= esc_mod;
            out_valid                  <= 1'b1;
            state                      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `MEC_ASSERT(a_it_range, clk, rst, (state != S_IDLE) |-> it_cnt <= ITW'(BATCH))
  `MEC_ASSERT(a_eval_after_mul, clk, rst, (state == S_EVAL) |-> $past(state == S_MUL_HI))
  `MEC_ASSERT(a_batch_count, clk, rst, (state != S_IDLE && !phase2) |-> count == done)

endmodule

### tb/mec_checker.sv
`timescale 1ns / 100ps

module mec_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_ready,
  input  mec_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_ready,
  input  mec_pkg::out_t out_data,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [63:0]   pwdata,
  input  logic          pready,
  output int            errors,
  output int            pending
);

  localparam longint BAILOUT = 64'd20 << 44;

  // shadow copy of the register file
  logic signed [47:0] org_re, org_im;
  logic [46:0]        pitch;
  logic [19:0]        iter_cap;

  mec_pkg::out_t escape_q[$];

  // truncated magnitude product, capped at 2^60
  function automatic logic [60:0] fx_mul(logic [47:0] a, logic [47:0] b);
    logic [95:0] p;
    p = ({48'b0, a} * {48'b0, b}) >> 44;
    if (p > 96'(mec_pkg::PCAP)) p = 96'(mec_pkg::PCAP);
    return p[60:0];
  endfunction

  function automatic logic [47:0] fx_abs(logic signed [47:0] v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint fx_smul(logic signed [47:0] a, logic signed [47:0] b);
    longint r;
    r = longint'(fx_mul(fx_abs(a), fx_abs(b)));
    return ((a < 0) != (b < 0)) ? -r : r;
  endfunction

  function automatic logic signed [47:0] clamp48(longint v);
    if (v > longint'(mec_pkg::Z_MAX)) return mec_pkg::Z_MAX;
    if (v < longint'(mec_pkg::Z_MIN)) return mec_pkg::Z_MIN;
    return v[47:0];
  endfunction

  function automatic logic [51:0] mod_sq(mec_pkg::point_t z);
    logic [61:0] m;
    m = fx_mul(fx_abs(z.re), fx_abs(z.re)) + fx_mul(fx_abs(z.im), fx_abs(z.im));
    return (m > 62'(mec_pkg::MOD_MAX)) ? mec_pkg::MOD_MAX : m[51:0];
  endfunction

  function automatic mec_pkg::point_t z_step(mec_pkg::point_t z, mec_pkg::point_t c);
    mec_pkg::point_t n;
    n.re = clamp48(fx_smul(z.re, z.re) - fx_smul(z.im, z.im) + longint'(c.re));
    n.im = clamp48(2 * fx_smul(z.re, z.im) + longint'(c.im));
    return n;
  endfunction

  // escape count for one sample under the current settings
  function automatic mec_pkg::out_t escape_count(mec_pkg::in_t s);
    mec_pkg::point_t c, z, saved, start;
    logic [51:0] m;
    int unsigned cnt, done;
    bit hit;
    mec_pkg::out_t r;
    c.re = clamp48(longint'(org_re) + longint'({52'b0, s.column}) * longint'({17'b0, pitch}));
    c.im = clamp48(longint'(org_im) + longint'({52'b0, s.row}) * longint'({17'b0, pitch}));
    z = c;
    start = '0;
    cnt = 0;
    done = 0;
    hit = 0;
    // batched phase
    do begin
      saved = z;
      for (int k = 0; k < 8; k++) z = z_step(z, c);
      if (mod_sq(z) > BAILOUT) begin
        hit = 1;
        start = saved;
      end else begin
        cnt += 8;
      end
      done += 8;
    end while (done < iter_cap && !hit);
    // single steps
    r = '0;
    z = start;
    for (int k = 0; k < 8; k++) begin
      z = z_step(z, c);
      m = mod_sq(z);
      if (m > BAILOUT) begin
        r.escaped = 1'b1;
        r.escape_modulus_sq = m;
        break;
      end
      cnt++;
    end
    r.iteration_count = cnt[20:0];
    return r;
  endfunction

  always @(posedge clk) begin
    mec_pkg::out_t e;
    if (rst) begin
      org_re   <= mec_pkg::ORIGIN_RE_RST;
      org_im   <= mec_pkg::ORIGIN_IM_RST;
      pitch    <= mec_pkg::STEP_RST;
      iter_cap <= mec_pkg::LIMIT_RST;
      errors   = 0;
      escape_q.delete();
    end else begin
      // register writes
      if (psel && penable && pwrite && pready) begin
        case (mec_pkg::reg_idx_t'(paddr[4:3]))
          mec_pkg::REG_ORIGIN_RE: org_re   <= pwdata[47:0];
          mec_pkg::REG_ORIGIN_IM: org_im   <= pwdata[47:0];
          mec_pkg::REG_STEP:      pitch    <= pwdata[46:0];
          mec_pkg::REG_LIMIT:     iter_cap <= pwdata[19:0];
          default: ;
        endcase
      end
      // input beat
      if (in_valid && in_ready) escape_q.push_back(escape_count(in_data));
      // result beat
      if (out_valid && out_ready) begin
        if (escape_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result beat %p", out_data);
        end else begin
          e = escape_q.pop_front();
          if (out_data.iteration_count !== e.iteration_count ||
              out_data.escaped !== e.escaped ||
              out_data.escape_modulus_sq !== e.escape_modulus_sq) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: count %0d/%0d escaped %0d/%0d modsq %0h/%0h (exp/got)",
                       e.iteration_count, out_data.iteration_count, e.escaped,
                       out_data.escaped, e.escape_modulus_sq, out_data.escape_modulus_sq);
          end
        end
      end
    end
    pending = escape_q.size();
  end

endmodule

### tb/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int CYCLE_LIMIT = 4_000_000;

  logic          clk = 0;
  logic          rst = 1;
  logic          in_valid = 0;
  logic          in_ready;
  mec_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_ready = 0;
  mec_pkg::out_t out_data;
  logic          psel = 0, penable = 0, pwrite = 0;
  logic [4:0]    paddr = '0;
  logic [63:0]   pwdata = '0;
  logic [63:0]   prdata;
  logic          pready;
  int            errors, pending;
  int            cycles = 0;
  int            burst_left = 0;
  int            stall_pct = 0;

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  mandelbrot_escape_count DUT (
    .clk, .rst, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  mec_checker u_checker (
    .clk, .rst, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready, .errors, .pending
  );

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // result side back-pressure
  always @(negedge clk) out_ready <= ($urandom_range(0, 99) >= stall_pct);

  task automatic reg_write(mec_pkg::reg_idx_t idx, logic [63:0] val);
    @(negedge clk);
    psel = 1; pwrite = 1; penable = 0; paddr = {idx, 3'b000}; pwdata = val;
    @(negedge clk);
    penable = 1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 0; penable = 0; pwrite = 0;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic set_tile(logic [47:0] ore, logic [47:0] oim, logic [46:0] stp,
                          logic [19:0] lim);
    drain();
    reg_write(mec_pkg::REG_ORIGIN_RE, {16'b0, ore});
    reg_write(mec_pkg::REG_ORIGIN_IM, {16'b0, oim});
    reg_write(mec_pkg::REG_STEP, {17'b0, stp});
    reg_write(mec_pkg::REG_LIMIT, {44'b0, lim});
  endtask

  // one sample beat, sent in bursts with gaps between them
  task automatic send_sample(logic [11:0] col, logic [11:0] rw);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        @(negedge clk);
        in_valid = 0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    @(negedge clk);
    in_valid = 1;
    in_data.column = col;
    in_data.row = rw;
    do @(posedge clk); while (!in_ready);
    burst_left--;
  endtask

  initial begin
    logic [47:0] ore, oim;
    logic [46:0] stp;
    logic [19:0] lim;
    repeat (2) @(negedge clk);
    rst = 0;

    // reset settings, corners of the tile and one inner point
    send_sample(12'd0, 12'd0);
    send_sample(12'hFFF, 12'hFFF);
    send_sample(12'd0, 12'hFFF);
    send_sample(12'hFFF, 12'd0);
    send_sample(12'd2048, 12'd1024);
    // zero limit, and a limit not a multiple of the batch
    set_tile(mec_pkg::ORIGIN_RE_RST, mec_pkg::ORIGIN_IM_RST, mec_pkg::STEP_RST, 20'd0);
    send_sample(12'd1024, 12'd1024);
    send_sample(12'd3000, 12'd1500);
    set_tile(mec_pkg::ORIGIN_RE_RST, mec_pkg::ORIGIN_IM_RST, mec_pkg::STEP_RST, 20'd9);
    send_sample(12'd1024, 12'd1024);
    send_sample(12'd100, 12'd4000);
    // c at the origin never escapes
    set_tile(48'd0, 48'd0, 47'd0, 20'd20);
    send_sample(12'd5, 12'd7);
    // most negative corner, zero step
    set_tile(mec_pkg::Z_MIN, mec_pkg::Z_MIN, 47'd0, 20'd16);
    send_sample(12'hFFF, 12'hFFF);
    // huge step saturates c
    set_tile(mec_pkg::Z_MIN, mec_pkg::Z_MIN, 47'h7FFF_FFFF_FFFF, 20'd8);
    send_sample(12'hFFF, 12'hFFF);
    send_sample(12'd1, 12'd0);
    send_sample(12'h800, 12'h800);
    // largest limit with points that escape at once
    set_tile(mec_pkg::Z_MAX, mec_pkg::Z_MAX, 47'h7FFF_FFFF_FFFF, 20'hFFFFF);
    send_sample(12'd0, 12'd0);
    send_sample(12'hFFF, 12'hFFF);
    send_sample(12'hA5A, 12'h5A5);

    // random tiles
    for (int ph = 0; ph < 10; ph++) begin
      stall_pct = (ph % 3 == 0) ? 0 : $urandom_range(10, 80);
      if (ph == 3) begin
        // noise: any origin and step values
        ore = 48'({$urandom(), $urandom()});
        oim = 48'({$urandom(), $urandom()});
        stp = 47'({$urandom(), $urandom()});
      end else begin
        ore = 48'(longint'($urandom_range(0, 3000)) * (64'd1 << 44) / 1000 - (64'd5 << 43));
        oim = 48'(longint'($urandom_range(0, 2400)) * (64'd1 << 44) / 1000 - (64'd6 << 42));
        stp = 47'((64'd1 << 44) >> $urandom_range(8, 14));
      end
      case ($urandom_range(0, 9))
        0: lim = 20'd256;
        1: lim = 20'd0;
        default: lim = 20'($urandom_range(1, 64));
      endcase
      set_tile(ore, oim, stp, lim);
      for (int n = 0; n < 100; n++) begin
        if (ph == 5 && n == 50) drain();
        send_sample(12'($urandom()), 12'($urandom()));
      end
    end

    drain();
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
